// File: rtl/core/dmd_pkg.sv
// shared types, codes and constants of the distance motion detector
package dmd_pkg;

  // window depths by default
  localparam int DISTANCE_WINDOW_DEFAULT  = 16;
  localparam int DEVIATION_WINDOW_DEFAULT = 16;

  // field widths
  localparam int CM_W    = 9;
  localparam int MM_W    = 13;
  localparam int COUNT_W = 8;
  localparam int DET_W   = 2;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HITS      = 1'd1;
  localparam logic [MM_W-1:0]    THRESHOLD_RESET = 13'd100;
  localparam logic [COUNT_W-1:0] HITS_RESET      = 8'd3;

  // action codes
  localparam logic ACT_READING   = 1'b0;
  localparam logic ACT_LOAD_SKIP = 1'b1;

  // detection state codes
  localparam logic [DET_W-1:0] DET_UNKNOWN  = 2'd0;
  localparam logic [DET_W-1:0] DET_NONE     = 2'd1;
  localparam logic [DET_W-1:0] DET_MOVEMENT = 2'd2;

  typedef struct packed {
    logic               action;
    logic [CM_W-1:0]    distance_cm;
    logic               out_of_range;
    logic [COUNT_W-1:0] skip_count;
  } sample_t;

  typedef struct packed {
    logic               sample_used;
    logic [DET_W-1:0]   detection_state;
    logic               state_changed;
    logic [MM_W-1:0]    mean_distance_mm;
    logic [MM_W-1:0]    mean_deviation_mm;
    logic [COUNT_W-1:0] hit_count;
  } result_t;

endpackage

// File: rtl/core/dmd_ram.sv
// generic single write port ram with registered read
module dmd_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/distance_motion_detector_top.sv
// top level of the distance motion detector: skip logic, window rams and hit counter
//
//   channel   direction  handshake                  payload
//   sample    in         sample_valid/sample_ready  sample (sample_t)
//   result    out        result_valid/result_ready  result (result_t)
//   cfg       in         cfg_we                     cfg_index, cfg_data
//
// one sample per cycle unless stalled; samples pass s1 to s6, then the result reg.
// the seven stages advance together; a stalled result register stalls them all, so
// sample_ready follows result_ready while the result register is full.
// each window ram is read one stage before its write, so overlapping accesses never
// meet the same entry for windows of two or more. reset clears control and sums;
// window contents read before being written are never used.
module distance_motion_detector_top
  import dmd_pkg::*;
#(
  parameter int DISTANCE_WINDOW  = DISTANCE_WINDOW_DEFAULT,
  parameter int DEVIATION_WINDOW = DEVIATION_WINDOW_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  sample_t                sample,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // derived widths
  localparam int D_ADDR_W = $clog2(DISTANCE_WINDOW);
  localparam int V_ADDR_W = $clog2(DEVIATION_WINDOW);
  localparam int D_FILL_W = $clog2(DISTANCE_WINDOW + 1);
  localparam int V_FILL_W = $clog2(DEVIATION_WINDOW + 1);
  localparam int D_SUM_W  = MM_W + D_ADDR_W;
  localparam int V_SUM_W  = MM_W + V_ADDR_W;

  // reciprocals for exact floor division of the sums by the window depth
  localparam int D_SHIFT = D_SUM_W + D_ADDR_W;
  localparam int V_SHIFT = V_SUM_W + V_ADDR_W;
  localparam logic [63:0] D_RECIP_FULL =
      ((64'd1 << D_SHIFT) + 64'(DISTANCE_WINDOW) - 64'd1) / 64'(DISTANCE_WINDOW);
  localparam logic [63:0] V_RECIP_FULL =
      ((64'd1 << V_SHIFT) + 64'(DEVIATION_WINDOW) - 64'd1) / 64'(DEVIATION_WINDOW);
  localparam logic [D_SUM_W:0] D_RECIP = D_RECIP_FULL[D_SUM_W:0];
  localparam logic [V_SUM_W:0] V_RECIP = V_RECIP_FULL[V_SUM_W:0];
  localparam int D_PROD_W = 2 * D_SUM_W + 1;
  localparam int V_PROD_W = 2 * V_SUM_W + 1;

  localparam logic [D_FILL_W-1:0] D_FULL     = D_FILL_W'(DISTANCE_WINDOW);
  localparam logic [D_FILL_W-1:0] D_NEARFULL = D_FILL_W'(DISTANCE_WINDOW - 1);
  localparam logic [V_FILL_W-1:0] V_FULL     = V_FILL_W'(DEVIATION_WINDOW);
  localparam logic [V_FILL_W-1:0] V_NEARFULL = V_FILL_W'(DEVIATION_WINDOW - 1);
  localparam logic [D_ADDR_W-1:0] D_LAST     = D_ADDR_W'(DISTANCE_WINDOW - 1);
  localparam logic [V_ADDR_W-1:0] V_LAST     = V_ADDR_W'(DEVIATION_WINDOW - 1);

  // configuration registers
  logic [MM_W-1:0]    deviation_threshold_mm;
  logic [COUNT_W-1:0] hits_required;

  always_ff @(posedge clk) begin
    if (rst) begin
      deviation_threshold_mm <= THRESHOLD_RESET;
      hits_required          <= HITS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD: deviation_threshold_mm <= cfg_data[MM_W-1:0];
        CFG_HITS:      hits_required          <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance and input transfer
  logic advance;
  logic accept;

  assign advance      = !result_valid || result_ready;
  assign sample_ready = advance;
  assign accept       = sample_valid && sample_ready;

  // control state decided at transfer time
  logic [COUNT_W-1:0]  skip_left;
  logic [D_FILL_W-1:0] distance_fill;
  logic [D_ADDR_W-1:0] distance_slot;
  logic [V_FILL_W-1:0] deviation_fill;
  logic [V_ADDR_W-1:0] deviation_slot;

  logic [COUNT_W-1:0]  skip_next;
  logic                take;
  logic                d_full;
  logic                d_mean;
  logic                v_full;
  logic                used;
  logic [MM_W-1:0]     mm;

  always_comb begin
    skip_next = (skip_left != '0) ? skip_left - COUNT_W'(1) : skip_left;
    take      = (sample.action == ACT_READING) && (skip_next == '0) && !sample.out_of_range;
    d_full    = (distance_fill == D_FULL);
    d_mean    = take && (d_full || distance_fill == D_NEARFULL);
    v_full    = (deviation_fill == V_FULL);
    used      = d_mean && (v_full || deviation_fill == V_NEARFULL);
    // times ten as shift and add
    mm = (MM_W'(sample.distance_cm) << 3) + (MM_W'(sample.distance_cm) << 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_left      <= '0;
      distance_fill  <= '0;
      distance_slot  <= '0;
      deviation_fill <= '0;
      deviation_slot <= '0;
    end else if (accept) begin
      if (sample.action == ACT_LOAD_SKIP) begin
        skip_left <= sample.skip_count;
      end else begin
        skip_left <= skip_next;
      end
      if (take) begin
        if (!d_full) begin
          distance_fill <= distance_fill + D_FILL_W'(1);
        end
        distance_slot <= (distance_slot == D_LAST) ? '0 : distance_slot + D_ADDR_W'(1);
      end
      if (d_mean) begin
        if (!v_full) begin
          deviation_fill <= deviation_fill + V_FILL_W'(1);
        end
        deviation_slot <= (deviation_slot == V_LAST) ? '0 : deviation_slot + V_ADDR_W'(1);
      end
    end
  end

  // distance window ram: read at transfer, written one stage later
  logic [MM_W-1:0]     d_old;
  logic                d_we;
  logic [D_ADDR_W-1:0] s1_dslot;
  logic [MM_W-1:0]     s1_mm;

  dmd_ram #(
    .WIDTH (MM_W),
    .DEPTH (DISTANCE_WINDOW)
  ) u_distance_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (s1_dslot),
    .wdata (s1_mm),
    .re    (accept && take),
    .raddr (distance_slot),
    .rdata (d_old)
  );

  // pipeline valid bits
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
    end
  end

  // stage 1: distance sum update
  logic                s1_take, s1_dfull, s1_dmean, s1_vfull, s1_used;
  logic [V_ADDR_W-1:0] s1_vslot;
  logic [D_SUM_W-1:0]  distance_sum;
  logic [D_SUM_W-1:0]  distance_sum_next;

  assign d_we = advance && s1_valid && s1_take;

  always_comb begin
    distance_sum_next = distance_sum;
    if (s1_take) begin
      distance_sum_next = distance_sum - (s1_dfull ? D_SUM_W'(d_old) : '0) + D_SUM_W'(s1_mm);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_sum <= '0;
    end else if (d_we) begin
      distance_sum <= distance_sum_next;
    end
  end

  // stage 2: distance mean product
  logic                s2_dmean, s2_vfull, s2_used;
  logic [V_ADDR_W-1:0] s2_vslot;
  logic [MM_W-1:0]     s2_mm;
  logic [D_SUM_W-1:0]  s2_sum;
  logic                s2_vwrite;

  // stage 3: distance mean, absolute deviation, deviation ram read
  logic                s3_dmean, s3_vwrite, s3_vfull, s3_used;
  logic [V_ADDR_W-1:0] s3_vslot;
  logic [MM_W-1:0]     s3_mm;
  logic [D_PROD_W-1:0] s3_prod;
  logic [MM_W-1:0]     last_mean_distance;
  logic [MM_W-1:0]     mean_calc;
  logic [MM_W-1:0]     mean_dist;
  logic [MM_W-1:0]     dev;

  always_comb begin
    mean_calc = s3_prod[D_SHIFT +: MM_W];
    mean_dist = s3_dmean ? mean_calc : last_mean_distance;
    dev       = (s3_mm > mean_calc) ? s3_mm - mean_calc : mean_calc - s3_mm;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_mean_distance <= '0;
    end else if (advance && s3_valid && s3_dmean) begin
      last_mean_distance <= mean_calc;
    end
  end

  // stage 4: deviation sum update
  logic                s4_vwrite, s4_vfull, s4_used;
  logic [V_ADDR_W-1:0] s4_vslot;
  logic [MM_W-1:0]     s4_dev;
  logic [MM_W-1:0]     s4_mean_dist;
  logic [MM_W-1:0]     v_old;
  logic                v_we;
  logic [V_SUM_W-1:0]  deviation_sum;
  logic [V_SUM_W-1:0]  deviation_sum_next;

  // deviation window ram: read in stage 3, written in stage 4
  dmd_ram #(
    .WIDTH (MM_W),
    .DEPTH (DEVIATION_WINDOW)
  ) u_deviation_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (s4_vslot),
    .wdata (s4_dev),
    .re    (advance && s3_valid && s3_vwrite),
    .raddr (s3_vslot),
    .rdata (v_old)
  );

  assign v_we = advance && s4_valid && s4_vwrite;

  always_comb begin
    deviation_sum_next = deviation_sum;
    if (s4_vwrite) begin
      deviation_sum_next = deviation_sum - (s4_vfull ? V_SUM_W'(v_old) : '0)
                           + V_SUM_W'(s4_dev);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deviation_sum <= '0;
    end else if (v_we) begin
      deviation_sum <= deviation_sum_next;
    end
  end

  // stage 5: deviation mean product
  logic               s5_used;
  logic [MM_W-1:0]    s5_mean_dist;
  logic [V_SUM_W-1:0] s5_sum;

  // stage 6: hit counter and detection state
  logic                s6_used;
  logic [MM_W-1:0]     s6_mean_dist;
  logic [V_PROD_W-1:0] s6_prod;
  logic [MM_W-1:0]     last_mean_deviation;
  logic [COUNT_W-1:0]  hit_counter;
  logic [DET_W-1:0]    present_state;
  logic [DET_W-1:0]    prior_state;
  logic [MM_W-1:0]     mean_dev;
  logic [COUNT_W-1:0]  hit_next;
  logic [DET_W-1:0]    present_next;
  logic [DET_W-1:0]    prior_next;

  always_comb begin
    mean_dev     = s6_used ? s6_prod[V_SHIFT +: MM_W] : last_mean_deviation;
    hit_next     = hit_counter;
    present_next = present_state;
    prior_next   = prior_state;
    if (s6_used) begin
      if (mean_dev >= deviation_threshold_mm && hit_counter < hits_required) begin
        hit_next = hit_counter + COUNT_W'(1);
      end else if (mean_dev <= deviation_threshold_mm && hit_counter != '0) begin
        hit_next = hit_counter - COUNT_W'(1);
      end
      if (hit_next >= hits_required) begin
        prior_next   = present_state;
        present_next = DET_MOVEMENT;
      end else if (hit_next == '0) begin
        prior_next   = present_state;
        present_next = DET_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_mean_deviation <= '0;
      hit_counter         <= '0;
      present_state       <= DET_UNKNOWN;
      prior_state         <= DET_UNKNOWN;
      result_valid        <= 1'b0;
    end else if (advance) begin
      result_valid <= s6_valid;
      if (s6_valid) begin
        last_mean_deviation <= mean_dev;
        hit_counter         <= hit_next;
        present_state       <= present_next;
        prior_state         <= prior_next;
      end
    end
  end

  // pipeline payload registers
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_take  <= take;
      s1_dfull <= d_full;
      s1_dmean <= d_mean;
      s1_vfull <= v_full;
      s1_used  <= used;
      s1_dslot <= distance_slot;
      s1_vslot <= deviation_slot;
      s1_mm    <= mm;

      s2_dmean  <= s1_dmean;
      s2_vwrite <= s1_dmean;
      s2_vfull  <= s1_vfull;
      s2_used   <= s1_used;
      s2_vslot  <= s1_vslot;
      s2_mm     <= s1_mm;
      s2_sum    <= distance_sum_next;

      s3_dmean  <= s2_dmean;
      s3_vwrite <= s2_vwrite;
      s3_vfull  <= s2_vfull;
      s3_used   <= s2_used;
      s3_vslot  <= s2_vslot;
      s3_mm     <= s2_mm;
      s3_prod   <= D_PROD_W'(s2_sum) * D_PROD_W'(D_RECIP);

      s4_vwrite    <= s3_vwrite;
      s4_vfull     <= s3_vfull;
      s4_used      <= s3_used;
      s4_vslot     <= s3_vslot;
      s4_dev       <= dev;
      s4_mean_dist <= mean_dist;

      s5_used      <= s4_used;
      s5_mean_dist <= s4_mean_dist;
      s5_sum       <= deviation_sum_next;

      s6_used      <= s5_used;
      s6_mean_dist <= s5_mean_dist;
      s6_prod      <= V_PROD_W'(s5_sum) * V_PROD_W'(V_RECIP);

      result.sample_used       <= s6_used;
      result.detection_state   <= present_next;
      result.state_changed     <= (present_next != prior_next);
      result.mean_distance_mm  <= s6_mean_dist;
      result.mean_deviation_mm <= mean_dev;
      result.hit_count         <= hit_next;
    end
  end

endmodule
